@@ hdl/svsb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// svsb_pkg
// Shared types and constants for the session VWAP band block.
// ----------------------------------------------------------------------------
package svsb_pkg;

  localparam int unsigned DAY_SECONDS = 86400;

  // ceil(2^40 / 675): day quotient of (t >> 7), exact below 2^27
  localparam logic [63:0] DAY_RECIP = 64'd1628906116;

  // ceil(2^65 / 3): exact quotient by three below 2^64
  localparam logic [63:0] DIV3_RECIP = 64'hAAAA_AAAA_AAAA_AAAB;

  localparam logic [47:0] VOL_MAX = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    CFG_OFFSET = 2'd0,
    CFG_BAND   = 2'd1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DAY,
    ST_TP,
    ST_MUL1,
    ST_DIV1,
    ST_MUL2,
    ST_MUL3,
    ST_DIV2,
    ST_SQRT,
    ST_BAND,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } op_t;

  typedef struct packed {
    logic  start;
    op_t   op;
    logic [127:0] a;
    logic [63:0]  b;
  } alu_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] res;
  } alu_rsp_t;

endpackage
`default_nettype wire

@@ hdl/svsb_alu.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// svsb_alu
// Shared bit-serial unit: 64x64 multiply, 128/64 divide, 64-bit square root.
// ----------------------------------------------------------------------------
module svsb_alu (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire svsb_pkg::alu_req_t req,
  output svsb_pkg::alu_rsp_t      rsp
);

  logic                busy_r, busy_nxt;
  svsb_pkg::op_t       op_r, op_nxt;
  logic [6:0]          cnt_r, cnt_nxt;
  logic [127:0]        acc_r, acc_nxt;
  logic [127:0]        x_r, x_nxt;
  logic [63:0]         rem_r, rem_nxt;
  logic [63:0]         b_r, b_nxt;
  logic                done_r, done_nxt;
  logic [64:0]         rsh;
  logic [65:0]         sq_rem;
  logic [65:0]         sq_try;

  always_comb begin
    busy_nxt = busy_r;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    b_nxt    = b_r;
    done_nxt = 1'b0;
    rsh      = '0;
    sq_rem   = '0;
    sq_try   = '0;
    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      x_nxt    = req.a;
      b_nxt    = req.b;
      acc_nxt  = '0;
      rem_nxt  = '0;
      case (req.op)
        svsb_pkg::OP_MUL:  cnt_nxt = 7'd63;
        svsb_pkg::OP_DIV:  cnt_nxt = 7'd127;
        svsb_pkg::OP_SQRT: cnt_nxt = 7'd31;
        default:           cnt_nxt = 7'd0;
      endcase
    end else if (busy_r) begin
      case (op_r)
        svsb_pkg::OP_MUL: begin
          if (x_r[cnt_r[5:0]])
            acc_nxt = (acc_r << 1) + {64'd0, b_r};
          else
            acc_nxt = acc_r << 1;
        end
        svsb_pkg::OP_DIV: begin
          rsh = {rem_r, x_r[cnt_r]};
          if (rsh >= {1'b0, b_r}) begin
            rem_nxt = 64'(rsh - {1'b0, b_r});
            acc_nxt = {acc_r[126:0], 1'b1};
          end else begin
            rem_nxt = rsh[63:0];
            acc_nxt = {acc_r[126:0], 1'b0};
          end
        end
        svsb_pkg::OP_SQRT: begin
          sq_rem = {rem_r, x_r[{cnt_r[4:0], 1'b1}], x_r[{cnt_r[4:0], 1'b0}]};
          sq_try = {acc_r[63:0], 2'b01};
          if (sq_rem >= sq_try) begin
            rem_nxt = 64'(sq_rem - sq_try);
            acc_nxt = {acc_r[126:0], 1'b1};
          end else begin
            rem_nxt = sq_rem[63:0];
            acc_nxt = {acc_r[126:0], 1'b0};
          end
        end
        default: acc_nxt = acc_r;
      endcase
      if (cnt_r == 7'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    rem_r <= rem_nxt;
    b_r   <= b_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = acc_r;

endmodule
`default_nettype wire

@@ hdl/session_vwap_stdev_bands.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// session_vwap_stdev_bands
// Session-anchored VWAP with volume-weighted standard-deviation bands.
// ----------------------------------------------------------------------------
// Channel | Dir | Beat content
// in_*    | in  | tdata: timestamp, high, low, close, volume (160 bits)
// out_*   | out | tdata: mid, upper, lower (97 -> 104 bits); tuser: mid_valid, bands_valid
// cfg_*   | in  | index 0 session offset, index 1 band multiplier
//
// Everything runs on one bit-serial unit. A full update with bands takes six
// multiplies, two divides and one root. in_tready is high only when idle with
// the result register empty, so the next beat is taken only after the result
// has left. rst_n is synchronous; the result is held in out_tdata until taken.
// ----------------------------------------------------------------------------
module session_vwap_stdev_bands (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [159:0] in_tdata,   // timestamp, high, low, close, volume
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [103:0]      out_tdata,  // mid_price, upper_band, lower_band, zero pad
  output logic [1:0]        out_tuser,  // mid_valid, bands_valid
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [17:0]  cfg_data
);

  svsb_pkg::state_t   st_r, st_nxt;
  svsb_pkg::alu_req_t req;
  svsb_pkg::alu_rsp_t rsp;

  logic [17:0]  off_r;
  logic [11:0]  band_r;
  logic [17:0]  day_r;
  logic [47:0]  vol_r;
  logic [47:0]  mean_r;
  logic [63:0]  m2_r;
  logic [31:0]  h_r, l_r, c_r, w_r;
  logic         tneg_r;
  logic         neg_r;
  logic [47:0]  tp_r, mag_r;
  logic         ovalid_r;
  logic [103:0] odata_r;
  logic [1:0]   ouser_r;

  logic         in_acc;
  logic [33:0]  tsum;
  logic [33:0]  tabs;
  logic [17:0]  dayq;
  logic [33:0]  tp_num;
  logic [47:0]  tp_new;
  logic         tp_lt;
  logic [47:0]  mag_new;
  logic [48:0]  vsum;
  logic [47:0]  vol_new;
  logic [47:0]  newmean;
  logic [47:0]  d2;
  logic [63:0]  inc;
  logic [64:0]  m2sum;
  logic [63:0]  m2_new;
  logic [31:0]  midv;
  logic [36:0]  offs, upsum, lowlim, lowdiff;
  logic [31:0]  upper;
  logic [32:0]  lower;
  logic         bands_on;

  svsb_alu u_alu (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  assign in_tready = (st_r == svsb_pkg::ST_IDLE) && !ovalid_r;
  assign in_acc    = in_tvalid && in_tready;

  // floor division of a negative t goes through |t| + 86399
  assign tsum  = {2'b0, in_tdata[31:0]} + {{16{off_r[17]}}, off_r};
  assign tabs  = tsum[33] ? (34'd0 - tsum) + 34'(svsb_pkg::DAY_SECONDS - 32'd1) : tsum;
  assign dayq  = tneg_r ? 18'd0 - rsp.res[57:40] : rsp.res[57:40];

  assign tp_num  = {2'b0, h_r} + {2'b0, l_r} + {2'b0, c_r};
  assign tp_new  = rsp.res[112:65];
  assign tp_lt   = tp_new < mean_r;
  assign mag_new = tp_lt ? mean_r - tp_new : tp_new - mean_r;
  assign vsum    = {1'b0, vol_r} + {17'd0, w_r};
  assign vol_new = vsum[48] ? svsb_pkg::VOL_MAX : vsum[47:0];

  assign newmean = neg_r ? mean_r - rsp.res[47:0] : mean_r + rsp.res[47:0];
  assign d2      = neg_r ? newmean - tp_r : tp_r - newmean;

  assign inc     = (rsp.res[127:64] != 64'd0) ? '1 : rsp.res[63:0];
  assign m2sum   = {1'b0, m2_r} + {1'b0, inc};
  assign m2_new  = m2sum[64] ? '1 : m2sum[63:0];

  assign bands_on = (vol_r != 48'd0) && (band_r != 12'd0);

  assign midv    = mean_r[47:16];
  assign offs    = rsp.res[44:8];
  assign upsum   = {5'd0, midv} + offs;
  assign upper   = (upsum[36:32] != 5'd0) ? 32'hFFFF_FFFF : upsum[31:0];
  assign lowlim  = {5'd0, midv} + 37'h1_0000_0000;
  assign lowdiff = {5'd0, midv} - offs;
  assign lower   = (offs > lowlim) ? 33'h1_0000_0000 : lowdiff[32:0];

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      svsb_pkg::ST_IDLE: if (in_acc) st_nxt = svsb_pkg::ST_DAY;
      svsb_pkg::ST_DAY:  if (rsp.done) st_nxt = svsb_pkg::ST_TP;
      svsb_pkg::ST_TP: begin
        if (rsp.done) begin
          if (w_r != 32'd0) st_nxt = svsb_pkg::ST_MUL1;
          else if (bands_on) st_nxt = svsb_pkg::ST_DIV2;
          else st_nxt = svsb_pkg::ST_OUT;
        end
      end
      svsb_pkg::ST_MUL1: if (rsp.done) st_nxt = svsb_pkg::ST_DIV1;
      svsb_pkg::ST_DIV1: if (rsp.done) st_nxt = svsb_pkg::ST_MUL2;
      svsb_pkg::ST_MUL2: if (rsp.done) st_nxt = svsb_pkg::ST_MUL3;
      svsb_pkg::ST_MUL3: begin
        if (rsp.done) st_nxt = (band_r != 12'd0) ? svsb_pkg::ST_DIV2 : svsb_pkg::ST_OUT;
      end
      svsb_pkg::ST_DIV2: if (rsp.done) st_nxt = svsb_pkg::ST_SQRT;
      svsb_pkg::ST_SQRT: if (rsp.done) st_nxt = svsb_pkg::ST_BAND;
      svsb_pkg::ST_BAND: if (rsp.done) st_nxt = svsb_pkg::ST_IDLE;
      svsb_pkg::ST_OUT:  st_nxt = svsb_pkg::ST_IDLE;
      default:           st_nxt = svsb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req = '0;
    case (st_r)
      svsb_pkg::ST_IDLE: if (in_acc) begin
        req.start = 1'b1;
        req.op    = svsb_pkg::OP_MUL;
        req.a     = {101'd0, tabs[33:7]};
        req.b     = svsb_pkg::DAY_RECIP;
      end
      svsb_pkg::ST_DAY: if (rsp.done) begin
        req.start = 1'b1;
        req.op    = svsb_pkg::OP_MUL;
        req.a     = {78'd0, tp_num, 16'd0};
        req.b     = svsb_pkg::DIV3_RECIP;
      end
      svsb_pkg::ST_TP: if (rsp.done) begin
        if (w_r != 32'd0) begin
          req.start = 1'b1;
          req.op    = svsb_pkg::OP_MUL;
          req.a     = {80'd0, mag_new};
          req.b     = {32'd0, w_r};
        end else if (bands_on) begin
          req.start = 1'b1;
          req.op    = svsb_pkg::OP_DIV;
          req.a     = {64'd0, m2_r};
          req.b     = {16'd0, vol_r};
        end
      end
      svsb_pkg::ST_MUL1: if (rsp.done) begin
        req.start = 1'b1;
        req.op    = svsb_pkg::OP_DIV;
        req.a     = rsp.res;
        req.b     = {16'd0, vol_r};
      end
      svsb_pkg::ST_DIV1: if (rsp.done) begin
        req.start = 1'b1;
        req.op    = svsb_pkg::OP_MUL;
        req.a     = {80'd0, mag_r};
        req.b     = {16'd0, d2};
      end
      svsb_pkg::ST_MUL2: if (rsp.done) begin
        req.start = 1'b1;
        req.op    = svsb_pkg::OP_MUL;
        req.a     = {64'd0, rsp.res[95:32]};
        req.b     = {32'd0, w_r};
      end
      svsb_pkg::ST_MUL3: if (rsp.done && band_r != 12'd0) begin
        req.start = 1'b1;
        req.op    = svsb_pkg::OP_DIV;
        req.a     = {64'd0, m2_new};
        req.b     = {16'd0, vol_r};
      end
      svsb_pkg::ST_DIV2: if (rsp.done) begin
        req.start = 1'b1;
        req.op    = svsb_pkg::OP_SQRT;
        req.a     = {64'd0, rsp.res[63:0]};
      end
      svsb_pkg::ST_SQRT: if (rsp.done) begin
        req.start = 1'b1;
        req.op    = svsb_pkg::OP_MUL;
        req.a     = {116'd0, band_r};
        req.b     = {32'd0, rsp.res[31:0]};
      end
      default: req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= svsb_pkg::ST_IDLE;
      off_r    <= '0;
      band_r   <= 12'd512;
      day_r    <= '0;
      vol_r    <= '0;
      mean_r   <= '0;
      m2_r     <= '0;
      ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        case (cfg_index)
          svsb_pkg::CFG_OFFSET: off_r  <= cfg_data;
          svsb_pkg::CFG_BAND:   band_r <= cfg_data[11:0];
          default: ;
        endcase
      end
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      case (st_r)
        svsb_pkg::ST_DAY: if (rsp.done && dayq != day_r) begin
          day_r  <= dayq;
          vol_r  <= '0;
          mean_r <= '0;
          m2_r   <= '0;
        end
        svsb_pkg::ST_TP:   if (rsp.done && w_r != 32'd0) vol_r <= vol_new;
        svsb_pkg::ST_DIV1: if (rsp.done) mean_r <= newmean;
        svsb_pkg::ST_MUL3: if (rsp.done) m2_r <= m2_new;
        svsb_pkg::ST_BAND: if (rsp.done) ovalid_r <= 1'b1;
        svsb_pkg::ST_OUT:  ovalid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      h_r    <= in_tdata[63:32];
      l_r    <= in_tdata[95:64];
      c_r    <= in_tdata[127:96];
      w_r    <= in_tdata[159:128];
      tneg_r <= tsum[33];
    end
    if (st_r == svsb_pkg::ST_TP && rsp.done) begin
      tp_r  <= tp_new;
      neg_r <= tp_lt;
      mag_r <= mag_new;
    end
    if (st_r == svsb_pkg::ST_BAND && rsp.done) begin
      ouser_r <= 2'b11;
      odata_r <= {7'd0, lower, upper, midv};
    end
    if (st_r == svsb_pkg::ST_OUT) begin
      ouser_r <= {1'b0, vol_r != 48'd0};
      odata_r <= (vol_r != 48'd0) ? {72'd0, midv} : '0;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

endmodule
`default_nettype wire

@@ tb/session_vwap_stdev_bands_test.sv @@
// ----------------------------------------------------------------------------
// session_vwap_stdev_bands_test
// Drives candles into the session VWAP band block and checks every result
// against a local fixed-point model of the day split, the weighted Welford
// update and the band arithmetic, across several register settings.
// ----------------------------------------------------------------------------
module session_vwap_stdev_bands_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        mid_valid;
    logic        bands_valid;
    logic [31:0] mid;
    logic [31:0] upper;
    logic [32:0] lower;
  } band_res_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [159:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [17:0]  cfg_data = '0;

  session_vwap_stdev_bands dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic signed [17:0] offset_reg;
  logic [11:0]        band_reg;
  logic [17:0]        day_r;
  logic [63:0]        vol_r, mean_r, m2_r;
  band_res_t          band_q[$];
  int                 errors = 0;
  int                 idle_cycles = 0;
  int                 burst_left = 0;
  logic [31:0]        ts_cur, px_cur;

  function automatic logic [17:0] day_of(logic [31:0] ts);
    longint t, d;
    t = longint'({32'b0, ts}) + longint'(offset_reg);
    if (t >= 0) d = t / 86400;
    else d = -((-t + 86399) / 86400);
    return d[17:0];
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic predict_band(logic [159:0] d);
    logic [63:0]  h, l, c, w, tp, mag, d2, s, inc, mid, sig, offs, up;
    logic [127:0] p;
    logic [64:0]  sum;
    logic [17:0]  day;
    logic         neg;
    band_res_t    r;
    h = d[63:32]; l = d[95:64]; c = d[127:96]; w = d[159:128];
    day = day_of(d[31:0]);
    if (day != day_r) begin
      vol_r = 0; mean_r = 0; m2_r = 0; day_r = day;
    end
    if (w != 0) begin
      tp = ((h + l + c) << 16) / 3;
      neg = tp < mean_r;
      vol_r = vol_r + w;
      if (vol_r > {16'b0, svsb_pkg::VOL_MAX}) vol_r = {16'b0, svsb_pkg::VOL_MAX};
      mag = neg ? mean_r - tp : tp - mean_r;
      p = ({64'b0, mag} * {64'b0, w}) / {64'b0, vol_r};
      mean_r = neg ? mean_r - p[63:0] : mean_r + p[63:0];
      d2 = neg ? mean_r - tp : tp - mean_r;
      p = {64'b0, mag} * {64'b0, d2};
      s = p[95:32];
      p = {64'b0, s} * {64'b0, w};
      inc = (p[127:64] != 0) ? '1 : p[63:0];
      sum = {1'b0, m2_r} + {1'b0, inc};
      m2_r = sum[64] ? '1 : sum[63:0];
    end
    r = '0;
    if (vol_r != 0) begin
      mid = (mean_r >> 16) & 64'hFFFF_FFFF;
      r.mid_valid = 1'b1;
      r.mid = mid[31:0];
      if (band_reg != 0) begin
        sig = isqrt(m2_r / vol_r);
        offs = ({52'b0, band_reg} * sig) >> 8;
        up = mid + offs;
        if (up > 64'hFFFF_FFFF) up = 64'hFFFF_FFFF;
        r.bands_valid = 1'b1;
        r.upper = up[31:0];
        if (offs > mid + 64'h1_0000_0000) r.lower = 33'h1_0000_0000;
        else r.lower = mid[32:0] - offs[32:0];
      end
    end
    band_q.push_back(r);
  endtask

  always @(posedge clk) begin
    band_res_t e, a;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("session_vwap_stdev_bands_test failed");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      a = {out_tuser[0], out_tuser[1], out_tdata[31:0], out_tdata[63:32], out_tdata[96:64]};
      if (band_q.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, a);
        errors++;
      end else begin
        e = band_q.pop_front();
        if (e.mid_valid !== a.mid_valid)
          $display("%0t: mid_valid exp %b got %b", $time, e.mid_valid, a.mid_valid);
        if (e.bands_valid !== a.bands_valid)
          $display("%0t: bands_valid exp %b got %b", $time, e.bands_valid, a.bands_valid);
        if (e.mid !== a.mid) $display("%0t: mid exp %h got %h", $time, e.mid, a.mid);
        if (e.upper !== a.upper) $display("%0t: upper exp %h got %h", $time, e.upper, a.upper);
        if (e.lower !== a.lower) $display("%0t: lower exp %h got %h", $time, e.lower, a.lower);
        if (e !== a) errors++;
      end
    end
  end

  int stall_mode = 0;
  int stall_cnt = 0;
  always @(negedge clk) begin
    if (stall_cnt == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_cnt <= $urandom_range(50, 400);
    end else begin
      stall_cnt <= stall_cnt - 1;
    end
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send_candle(logic [31:0] ts, logic [31:0] h, logic [31:0] l,
                             logic [31:0] c, logic [31:0] w);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
      if (gap != 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {w, c, l, h, ts};
    do @(posedge clk); while (!in_tready);
    predict_band({w, c, l, h, ts});
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (band_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_reg(svsb_pkg::cfg_idx_t idx, logic [17:0] val);
    drain_results();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == svsb_pkg::CFG_OFFSET) offset_reg = val;
    else if (idx == svsb_pkg::CFG_BAND) band_reg = val[11:0];
  endtask

  task automatic test_empty_session();
    send_candle(32'd1000, 32'h100, 32'h100, 32'h100, 32'd0);
    send_candle(32'd200000, 32'hFFFF_FFFF, 32'h0, 32'h8000, 32'd0);
    send_candle(32'd200010, 32'h1234_5600, 32'h1234_0000, 32'h1234_2000, 32'd10);
    send_candle(32'd200020, 32'h1234_5600, 32'h1234_0000, 32'h1234_2000, 32'd0);
  endtask

  task automatic test_price_extremes();
    send_candle(32'd200100, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_candle(32'd200200, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
    send_candle(32'd200300, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'd1);
    send_candle(32'd200400, 32'h0, 32'h0, 32'h0, 32'd1);
  endtask

  task automatic test_day_rollover();
    send_candle(32'd259199, 32'h500, 32'h400, 32'h480, 32'd7);
    send_candle(32'd259200, 32'h500, 32'h400, 32'h480, 32'd7);
    send_candle(32'hFFFF_FFFF, 32'h900, 32'h100, 32'h500, 32'd3);
    send_candle(32'd0, 32'h900, 32'h100, 32'h500, 32'd3);
  endtask

  task automatic test_offsets();
    write_reg(svsb_pkg::CFG_OFFSET, -18'sd86400);
    send_candle(32'd86399, 32'h2000, 32'h1000, 32'h1800, 32'd5);
    send_candle(32'd86400, 32'h2000, 32'h1000, 32'h1800, 32'd5);
    write_reg(svsb_pkg::CFG_OFFSET, 18'sd86400);
    send_candle(32'd10, 32'h2000, 32'h1000, 32'h1800, 32'd5);
    write_reg(svsb_pkg::CFG_OFFSET, 18'h1FFFF);
    send_candle(32'd10, 32'h2000, 32'h1000, 32'h1800, 32'd5);
    write_reg(svsb_pkg::CFG_OFFSET, 18'h20000);
    send_candle(32'd10, 32'h2000, 32'h1000, 32'h1800, 32'd5);
    write_reg(svsb_pkg::cfg_idx_t'(2'd2), 18'h3FFFF);
    write_reg(svsb_pkg::cfg_idx_t'(2'd3), 18'h3FFFF);
    send_candle(32'd20, 32'h3000, 32'h1000, 32'h1800, 32'd9);
  endtask

  task automatic test_band_widths();
    write_reg(svsb_pkg::CFG_OFFSET, 18'd0);
    write_reg(svsb_pkg::CFG_BAND, 18'd4095);
    send_candle(32'd500000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd100);
    send_candle(32'd500001, 32'h0, 32'h0, 32'h0, 32'd100);
    write_reg(svsb_pkg::CFG_BAND, 18'd0);
    send_candle(32'd500002, 32'h100, 32'h0, 32'h0, 32'd1);
    write_reg(svsb_pkg::CFG_BAND, 18'd1);
    send_candle(32'd500003, 32'h100, 32'h0, 32'h0, 32'd0);
  endtask

  task automatic random_candle();
    logic [31:0] h, l, c, w;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 3) ts_cur = $urandom;
    else if (sel < 8) ts_cur = ts_cur + $urandom_range(40000, 200000);
    else ts_cur = ts_cur + $urandom_range(0, 3000);
    px_cur = px_cur + $urandom_range(0, 4096) - 2048;
    if ($urandom_range(0, 9) == 0) begin
      h = $urandom; l = $urandom; c = $urandom;
    end else begin
      h = px_cur + $urandom_range(0, 1024);
      l = px_cur - $urandom_range(0, 1024);
      c = px_cur + $urandom_range(0, 1024) - 512;
    end
    sel = $urandom_range(0, 99);
    if (sel < 10) w = 0;
    else if (sel < 20) w = $urandom;
    else w = $urandom_range(1, 5000);
    send_candle(ts_cur, h, l, c, w);
  endtask

  task automatic test_random();
    int ph, n;
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(svsb_pkg::CFG_OFFSET, 18'd0);
          write_reg(svsb_pkg::CFG_BAND, 18'd512);
        end
        1: begin
          write_reg(svsb_pkg::CFG_OFFSET, -18'sd86400);
          write_reg(svsb_pkg::CFG_BAND, 18'd4095);
        end
        2: begin
          write_reg(svsb_pkg::CFG_OFFSET, 18'sd86400);
          write_reg(svsb_pkg::CFG_BAND, 18'd0);
        end
        default: begin
          write_reg(svsb_pkg::CFG_OFFSET, 18'($urandom));
          write_reg(svsb_pkg::CFG_BAND, 18'($urandom_range(1, 4095)));
        end
      endcase
      px_cur = $urandom;
      ts_cur = $urandom;
      for (n = 0; n < 225; n++) begin
        random_candle();
        if (ph == 1 && n == 100) drain_results();
      end
    end
  endtask

  initial begin
    offset_reg = '0;
    band_reg = 12'd512;
    day_r = '0;
    vol_r = '0;
    mean_r = '0;
    m2_r = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_empty_session();
    test_price_extremes();
    test_day_rollover();
    test_offsets();
    test_band_widths();
    test_random();
    drain_results();
    if (errors == 0) $display("session_vwap_stdev_bands_test passed");
    else $display("session_vwap_stdev_bands_test failed");
    $finish;
  end
endmodule
